### src/slo_pkg.sv
// Package for the scanline overlay blend: item and status types, register
// indexes and blend constants. No dependencies.
`default_nettype none
package slo_pkg;

    localparam int unsigned DivSteps = 32;
    localparam int unsigned CntW     = $clog2(DivSteps);

    localparam logic [15:0] FULL_SQ      = 16'd65025;
    localparam logic [7:0]  FULL_ALPHA   = 8'd255;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SHOW  = 3'd0;
    localparam logic [2:0] REG_HIDE  = 3'd1;
    localparam logic [2:0] REG_RED   = 3'd2;
    localparam logic [2:0] REG_GREEN = 3'd3;
    localparam logic [2:0] REG_BLUE  = 3'd4;
    localparam logic [2:0] REG_ALPHA = 3'd5;

    // one classified pixel word
    typedef struct packed {
        logic       hide;
        logic       fs;
        logic       le;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_st_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } colour_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_BLEND
    } bk_state_t;

endpackage
`default_nettype wire

### src/slo_front.sv
// Front end: accepts pixel words, tracks the line within the stripe and tags
// each word as shown or overlaid. Depends on slo_pkg.
`default_nettype none
module slo_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              s_tuser,
    input  wire logic [9:0]        show_size,
    input  wire logic [9:0]        hide_size,
    input  wire slo_pkg::fifo_st_t fifo_st,
    output logic                   push,
    output slo_pkg::item_t         push_item
);

    logic [10:0] pos_reg, pos_next;
    logic [10:0] stripe_sum, shown, stripe, pos_eff;
    logic [11:0] nxt;
    logic        fallback;

    assign s_tready = !fifo_st.full;
    assign push     = s_tvalid && s_tready;

    // stripe geometry, with the two-line fallback when both sizes are zero
    always_comb begin
        stripe_sum = {1'b0, show_size} + {1'b0, hide_size};
        fallback   = (stripe_sum == 11'd0);
        shown      = fallback ? 11'd1 : {1'b0, show_size};
        stripe     = fallback ? 11'd2 : stripe_sum;
        pos_eff    = s_tuser ? 11'd0 : pos_reg;
        nxt        = {1'b0, pos_eff} + 12'd1;
        pos_next   = pos_reg;
        if (push) begin
            pos_next = pos_eff;
            if (s_tlast) begin
                pos_next = (nxt >= {1'b0, stripe}) ? 11'd0 : nxt[10:0];
            end
        end
    end

    always_comb begin
        push_item.red   = s_tdata[7:0];
        push_item.green = s_tdata[15:8];
        push_item.blue  = s_tdata[23:16];
        push_item.alpha = s_tdata[31:24];
        push_item.le    = s_tlast;
        push_item.fs    = s_tuser;
        push_item.hide  = (pos_eff >= shown);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 11'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

### src/slo_fifo.sv
// Two-entry queue between front and back end.
// Depends on slo_pkg.
`default_nettype none
module slo_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire slo_pkg::item_t push_item,
    input  wire logic           pop,
    output slo_pkg::item_t      head,
    output slo_pkg::fifo_st_t   fifo_st
);

    slo_pkg::item_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign head          = mem_reg[rd_reg];
    assign fifo_st.full  = (cnt_reg == 2'd2);
    assign fifo_st.empty = (cnt_reg == 2'd0);

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            if (push && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

### src/slo_back.sv
// Back end: passes shown words through and composites the overlay colour over
// tagged words with a two-way bit-serial divider for the weights, then holds the
// result word. Depends on slo_pkg.
`default_nettype none
module slo_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire slo_pkg::item_t    head,
    input  wire slo_pkg::fifo_st_t fifo_st,
    output logic                   pop,
    input  wire slo_pkg::colour_t  hide_col,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    slo_pkg::bk_state_t st_reg, st_next;
    slo_pkg::item_t     it_reg, it_next;
    logic [15:0] a_reg, a_next;
    logic        zero_reg, zero_next;
    logic [31:0] nwi_reg, nwi_next, nwo_reg, nwo_next;
    logic [15:0] rwi_reg, rwi_next, rwo_reg, rwo_next;
    logic [16:0] qwi_reg, qwi_next, qwo_reg, qwo_next;
    logic [slo_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic        mv_reg, mv_next;
    logic [31:0] md_reg, md_next;
    logic        ml_reg, ml_next, mu_reg, mu_next;

    logic        out_free;
    logic [7:0]  inv_ai, inv_ao;
    logic [15:0] a_calc, ai255, ao_w;
    logic [16:0] r2wi, r2wo, a_sum;
    logic        gewi, gewo;
    logic [16:0] wi, wo;
    logic [25:0] sr, sg, sb;

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;
    assign out_free = !mv_reg || m_tready;

    // operand setup from the queue head
    always_comb begin
        inv_ai = slo_pkg::FULL_ALPHA - hide_col.alpha;
        inv_ao = slo_pkg::FULL_ALPHA - head.alpha;
        a_calc = slo_pkg::FULL_SQ - inv_ai * inv_ao;
        ai255  = {hide_col.alpha, 8'd0} - {8'd0, hide_col.alpha};
        ao_w   = head.alpha * inv_ai;
    end

    // one restoring step on each weight
    always_comb begin
        r2wi = {rwi_reg, nwi_reg[31]};
        r2wo = {rwo_reg, nwo_reg[31]};
        gewi = (r2wi >= {1'b0, a_reg});
        gewo = (r2wo >= {1'b0, a_reg});
    end

    // blend of held pixel with the overlay colour
    always_comb begin
        wi    = zero_reg ? 17'd0 : qwi_reg;
        wo    = zero_reg ? 17'd0 : qwo_reg;
        sr    = hide_col.red   * wi + it_reg.red   * wo;
        sg    = hide_col.green * wi + it_reg.green * wo;
        sb    = hide_col.blue  * wi + it_reg.blue  * wo;
        a_sum = {1'b0, a_reg} + {9'd0, a_reg[15:8]} + 17'd1;
    end

    // sequencer
    always_comb begin
        st_next   = st_reg;
        it_next   = it_reg;
        a_next    = a_reg;
        zero_next = zero_reg;
        nwi_next  = nwi_reg;
        nwo_next  = nwo_reg;
        rwi_next  = rwi_reg;
        rwo_next  = rwo_reg;
        qwi_next  = qwi_reg;
        qwo_next  = qwo_reg;
        cnt_next  = cnt_reg;
        md_next   = md_reg;
        ml_next   = ml_reg;
        mu_next   = mu_reg;
        mv_next   = mv_reg && !m_tready;
        pop       = 1'b0;
        case (st_reg)
            slo_pkg::BK_IDLE: begin
                if (!fifo_st.empty) begin
                    if (head.hide) begin
                        pop       = 1'b1;
                        it_next   = head;
                        a_next    = a_calc;
                        zero_next = (a_calc == 16'd0);
                        nwi_next  = {ai255, 16'd0};
                        nwo_next  = {ao_w, 16'd0};
                        rwi_next  = 16'd0;
                        rwo_next  = 16'd0;
                        qwi_next  = 17'd0;
                        qwo_next  = 17'd0;
                        cnt_next  = '0;
                        st_next   = slo_pkg::BK_DIV;
                    end else if (out_free) begin
                        pop     = 1'b1;
                        md_next = {head.alpha, head.blue, head.green, head.red};
                        ml_next = head.le;
                        mu_next = head.fs;
                        mv_next = 1'b1;
                    end
                end
            end
            slo_pkg::BK_DIV: begin
                rwi_next = gewi ? 16'(r2wi - {1'b0, a_reg}) : r2wi[15:0];
                rwo_next = gewo ? 16'(r2wo - {1'b0, a_reg}) : r2wo[15:0];
                qwi_next = {qwi_reg[15:0], gewi};
                qwo_next = {qwo_reg[15:0], gewo};
                nwi_next = {nwi_reg[30:0], 1'b0};
                nwo_next = {nwo_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == slo_pkg::CntW'(slo_pkg::DivSteps - 1)) begin
                    st_next = slo_pkg::BK_BLEND;
                end
            end
            slo_pkg::BK_BLEND: begin
                if (out_free) begin
                    md_next = {a_sum[15:8], sb[23:16], sg[23:16], sr[23:16]};
                    ml_next = it_reg.le;
                    mu_next = it_reg.fs;
                    mv_next = 1'b1;
                    st_next = slo_pkg::BK_IDLE;
                end
            end
            default: st_next = slo_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= slo_pkg::BK_IDLE;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        it_reg   <= it_next;
        a_reg    <= a_next;
        zero_reg <= zero_next;
        nwi_reg  <= nwi_next;
        nwo_reg  <= nwo_next;
        rwi_reg  <= rwi_next;
        rwo_reg  <= rwo_next;
        qwi_reg  <= qwi_next;
        qwo_reg  <= qwo_next;
        cnt_reg  <= cnt_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
        mu_reg   <= mu_next;
    end

endmodule
`default_nettype wire

### src/scanline_overlay_blend.sv
// Scanline overlay blend top level: register file, front end, queue, back end.
// Throughput: one word per cycle on shown lines while the output is not stalled and
// the back end is idle; on overlaid lines the back end takes no new word until the
// 32-step bit-serial weight divider and the blend are done; the queue holds two words.
// Reset: synchronous active-low aresetn clears the line count, queue and output
// valid, and loads the register defaults. Depends on slo_pkg and submodules.
`default_nettype none
module scanline_overlay_blend (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red, green, blue, alpha (bits 7:0 up)
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // red, green, blue, alpha (bits 7:0 up)
    output logic             m_tlast,
    output logic             m_tuser    // frame_start
);

    logic [9:0]        show_reg, hide_reg;
    slo_pkg::colour_t  col_reg;
    logic              wr_en;
    logic [2:0]        idx;
    logic              push, pop;
    slo_pkg::item_t    push_item, head;
    slo_pkg::fifo_st_t fifo_st;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_reg      <= 10'd1;
            hide_reg      <= 10'd4;
            col_reg.red   <= 8'd0;
            col_reg.green <= 8'd0;
            col_reg.blue  <= 8'd0;
            col_reg.alpha <= 8'd255;
        end else if (wr_en) begin
            case (idx)
                slo_pkg::REG_SHOW:  show_reg      <= pwdata[9:0];
                slo_pkg::REG_HIDE:  hide_reg      <= pwdata[9:0];
                slo_pkg::REG_RED:   col_reg.red   <= pwdata[7:0];
                slo_pkg::REG_GREEN: col_reg.green <= pwdata[7:0];
                slo_pkg::REG_BLUE:  col_reg.blue  <= pwdata[7:0];
                slo_pkg::REG_ALPHA: col_reg.alpha <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (idx)
            slo_pkg::REG_SHOW:  prdata = {22'd0, show_reg};
            slo_pkg::REG_HIDE:  prdata = {22'd0, hide_reg};
            slo_pkg::REG_RED:   prdata = {24'd0, col_reg.red};
            slo_pkg::REG_GREEN: prdata = {24'd0, col_reg.green};
            slo_pkg::REG_BLUE:  prdata = {24'd0, col_reg.blue};
            slo_pkg::REG_ALPHA: prdata = {24'd0, col_reg.alpha};
            default:            prdata = 32'd0;
        endcase
    end

    slo_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .show_size (show_reg),
        .hide_size (hide_reg),
        .fifo_st   (fifo_st),
        .push      (push),
        .push_item (push_item)
    );

    slo_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .fifo_st   (fifo_st)
    );

    slo_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .fifo_st  (fifo_st),
        .pop      (pop),
        .hide_col (col_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // queue status is never both full and empty
    a_fifo_st: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_st.full && fifo_st.empty))
        else $error("queue full and empty at once");

    // nothing popped from an empty queue
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_st.empty)
        else $error("pop from empty queue");

    // no result right after reset
    a_reset_out: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule
`default_nettype wire
